/* sv/per_destination_token_bucket_policer_macros.svh */
// Assertion macros shared by the policer checker.
`ifndef PER_DESTINATION_TOKEN_BUCKET_POLICER_MACROS_SVH
`define PER_DESTINATION_TOKEN_BUCKET_POLICER_MACROS_SVH
// Same-cycle implication, disabled while in reset.
`define PTBP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("policer port check failed");
// Next-cycle implication, disabled while in reset.
`define PTBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("policer port check failed");
`endif

/* sv/ptbp_pkg.sv */
// Shared constants and payload types of the token bucket policer.
package ptbp_pkg;
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int AGE_W = IDX_W;
	localparam int LIM_W = IDX_W + 1;

	localparam logic [15:0] MIN_HEADER_BYTES = 16'd34;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	localparam logic [31:0] CAPACITY_RESET = 32'd1048576;
	localparam logic [31:0] NS_PER_TOKEN_RESET = 32'd10000;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_BYTES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NS_PER_TOKEN = 8'd1;

	localparam logic [33:0] EARNED_MAX = 34'h2_0000_0000;

	localparam int FRONT_DEPTH = 2;
	localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
	localparam int FRONT_CNT_W = $clog2(FRONT_DEPTH + 1);

	localparam int DIV_W = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	typedef struct packed {
		logic [15:0] captured_len;
		logic [15:0] ethertype;
		logic [31:0] dest_address;
		logic [15:0] frame_len;
		logic [63:0] timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic        verdict;
		logic        new_flow;
		logic [63:0] drop_total;
	} out_item_t;

	typedef struct packed {
		logic        is_ipv4;
		logic [31:0] dest_address;
		logic [15:0] frame_len;
		logic [63:0] timestamp_ns;
	} cls_item_t;

	typedef struct packed {
		logic [31:0] burst_bytes;
		logic [31:0] ns_per_token;
	} cfg_t;
endpackage

/* sv/ptbp_div.sv */
// Restoring divider, one quotient bit per cycle, for the token refill.
module ptbp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	import ptbp_pkg::*;

	logic [63:0]          dvd_q;
	logic [31:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic                 ge;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff = trial - {1'b0, divisor};
	assign ge = trial >= {1'b0, divisor};

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift the quotient bits in where the dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[31:0] : trial[31:0];
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;
endmodule

/* sv/ptbp_front.sv */
// Front end: accept frames, classify them, and queue them for the engine.
module ptbp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ptbp_pkg::in_item_t  frame,
	output logic                q_valid,
	output ptbp_pkg::cls_item_t q_item,
	input  logic                q_pop
);
	import ptbp_pkg::*;

	cls_item_t              slot_q [FRONT_DEPTH];
	logic [FRONT_PTR_W-1:0] wr_ptr_q;
	logic [FRONT_PTR_W-1:0] rd_ptr_q;
	logic [FRONT_CNT_W-1:0] count_q;
	cls_item_t              cls;
	logic                   do_push;
	logic                   do_pop;

	// Classify: full Ethernet plus IPv4 header and the IPv4 type
	always_comb begin
		cls.is_ipv4 = (frame.captured_len >= MIN_HEADER_BYTES)
			&& (frame.ethertype == ETHERTYPE_IPV4);
		cls.dest_address = frame.dest_address;
		cls.frame_len = frame.frame_len;
		cls.timestamp_ns = frame.timestamp_ns;
	end

	assign full = (count_q == FRONT_CNT_W'(FRONT_DEPTH));
	assign q_valid = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = q_pop && q_valid;
	assign q_item = slot_q[rd_ptr_q];

	// Hold queued items
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FRONT_PTR_W'(FRONT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FRONT_PTR_W'(FRONT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* sv/ptbp_engine.sv */
// Back end: bucket table search, refill, charge, LRU upkeep and result register.
module ptbp_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  ptbp_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  ptbp_pkg::cls_item_t q_item,
	output logic                q_pop,
	output logic                res_valid,
	output ptbp_pkg::out_item_t result,
	input  logic                res_pop
);
	import ptbp_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SCAN    = 8'b0000_0010,
		ST_RESOLVE = 8'b0000_0100,
		ST_READ    = 8'b0000_1000,
		ST_DIVIDE  = 8'b0001_0000,
		ST_SUM     = 8'b0010_0000,
		ST_CHARGE  = 8'b0100_0000,
		ST_FINISH  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	cls_item_t          item_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               cmp_v_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic [31:0]        rd_key_s1;
	logic [31:0]        rd_tok_q;
	logic [63:0]        rd_time_q;
	logic               hit_q;
	logic               free_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [IDX_W-1:0]   victim_idx_q;
	logic [AGE_W-1:0]   hit_age_q;
	logic [33:0]        earned_q;
	logic [31:0]        tok_q;
	logic               verdict_q;
	logic               new_flow_q;
	logic [63:0]        drop_q;
	logic               res_valid_q;
	out_item_t          result_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]         age_q [TABLE_ENTRIES];

	logic [31:0] key_mem  [TABLE_ENTRIES];
	logic [31:0] tok_mem  [TABLE_ENTRIES];
	logic [63:0] time_mem [TABLE_ENTRIES];

	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_tok;
	logic             age_we;
	logic [IDX_W-1:0] age_slot;
	logic [LIM_W-1:0] age_limit;
	logic             valid_set;
	logic             div_start;
	logic             div_done;
	logic [63:0]      div_quot;
	logic [34:0]      tok_sum;
	logic             fits;

	// Refill quotient of elapsed time over the token period
	ptbp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (item_q.timestamp_ns - rd_time_q),
		.divisor  (cfg.ns_per_token),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign div_start = (state_q == ST_READ);
	assign tok_sum = {3'b000, rd_tok_q} + {1'b0, earned_q};
	assign fits = (tok_q >= {16'h0000, item_q.frame_len});
	assign rd_addr = (state_q == ST_SCAN) ? scan_idx_q[IDX_W-1:0] : hit_idx_q;
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// Table writes and LRU update for a new or charged bucket
	always_comb begin
		mem_we = 1'b0;
		wr_addr = hit_idx_q;
		wr_tok = tok_q;
		age_we = 1'b0;
		age_slot = hit_idx_q;
		age_limit = {1'b0, hit_age_q};
		valid_set = 1'b0;
		if (state_q == ST_RESOLVE && !hit_q) begin
			mem_we = 1'b1;
			wr_addr = free_q ? free_idx_q : victim_idx_q;
			wr_tok = cfg.burst_bytes;
			age_we = 1'b1;
			age_slot = wr_addr;
			age_limit = free_q ? LIM_W'(TABLE_ENTRIES) : LIM_W'(TABLE_ENTRIES - 1);
			valid_set = 1'b1;
		end else if (state_q == ST_CHARGE) begin
			mem_we = 1'b1;
			wr_tok = fits ? tok_q - {16'h0000, item_q.frame_len} : tok_q;
			age_we = 1'b1;
		end
	end

	// Bucket memories, one read and one write port each
	always_ff @(posedge clk) begin
		rd_key_s1 <= key_mem[rd_addr];
		rd_tok_q <= tok_mem[rd_addr];
		rd_time_q <= time_mem[rd_addr];
		if (mem_we) begin
			key_mem[wr_addr] <= item_q.dest_address;
			tok_mem[wr_addr] <= wr_tok;
			time_mem[wr_addr] <= item_q.timestamp_ns;
		end
	end

	// Valid bits and recency ranks, one lane per entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (valid_set) begin
				valid_q[age_slot] <= 1'b1;
			end
			if (age_we) begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (IDX_W'(i) == age_slot) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && ({1'b0, age_q[i]} < age_limit)) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// Sequencer: scan, resolve, refill, charge, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			drop_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					hit_q <= 1'b0;
					free_q <= 1'b0;
					scan_idx_q <= '0;
					cmp_v_s1 <= 1'b0;
					if (q_valid) begin
						state_q <= q_item.is_ipv4 ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q != CNT_W'(TABLE_ENTRIES)) begin
						cmp_v_s1 <= 1'b1;
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						cmp_v_s1 <= 1'b0;
					end
					if (cmp_v_s1) begin
						if (valid_q[cmp_idx_s1]) begin
							if (rd_key_s1 == item_q.dest_address && !hit_q) begin
								hit_q <= 1'b1;
							end
						end else if (!free_q) begin
							free_q <= 1'b1;
						end
						if (cmp_idx_s1 == IDX_W'(TABLE_ENTRIES - 1)) begin
							state_q <= ST_RESOLVE;
						end
					end
				end
				ST_RESOLVE: begin
					cmp_v_s1 <= 1'b0;
					state_q <= hit_q ? ST_READ : ST_FINISH;
				end
				ST_READ: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_CHARGE;
				end
				ST_CHARGE: begin
					if (!fits) begin
						drop_q <= drop_q + 64'd1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers that follow the sequencer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			item_q <= q_item;
			verdict_q <= 1'b0;
			new_flow_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
			if (cmp_v_s1 && valid_q[cmp_idx_s1]) begin
				if (rd_key_s1 == item_q.dest_address && !hit_q) begin
					hit_idx_q <= cmp_idx_s1;
					hit_age_q <= age_q[cmp_idx_s1];
				end
				if (age_q[cmp_idx_s1] == AGE_W'(TABLE_ENTRIES - 1)) begin
					victim_idx_q <= cmp_idx_s1;
				end
			end else if (cmp_v_s1 && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
		if (state_q == ST_RESOLVE && !hit_q) begin
			new_flow_q <= 1'b1;
		end
		if (state_q == ST_DIVIDE && div_done) begin
			earned_q <= (div_quot > {30'd0, EARNED_MAX}) ? EARNED_MAX : div_quot[33:0];
		end
		if (state_q == ST_SUM) begin
			tok_q <= (tok_sum > {3'b000, cfg.burst_bytes}) ? cfg.burst_bytes
				: tok_sum[31:0];
		end
		if (state_q == ST_CHARGE) begin
			verdict_q <= !fits;
		end
		if (state_q == ST_FINISH && !res_valid_q) begin
			result_q.verdict <= verdict_q;
			result_q.new_flow <= new_flow_q;
			result_q.drop_total <= drop_q;
		end
	end

	assign res_valid = res_valid_q;
	assign result = result_q;
endmodule

/* sv/per_destination_token_bucket_policer.sv */
// Top level of the per-destination token bucket policer.
//
//  port group                       | dir | transfer when
//  push, full, frame                | in  | push && !full
//  empty, pop, result               | out | pop && !empty
//  cfg_valid, cfg_ready, cfg_index, | in  | cfg_valid && cfg_ready
//  cfg_data                         |     |
//
// A non-IPv4 or short frame goes from the idle state straight to the finish state in the engine.
// A new destination is found by a scan that reads the key memory one entry a cycle.
// A known destination is scanned the same way and then waits on the bit-serial divider for its refill.
// A two-entry front queue keeps taking frames while the engine works or a result waits.
// Reset clears valid bits, ranks and drop count and loads the configuration defaults at once; no clearing pass.
module per_destination_token_bucket_policer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  ptbp_pkg::in_item_t                   frame,
	output logic                                 empty,
	input  logic                                 pop,
	output ptbp_pkg::out_item_t                  result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ptbp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data
);
	import ptbp_pkg::*;

	cfg_t      cfg_q;
	logic      q_valid;
	cls_item_t q_item;
	logic      q_pop;
	logic      res_valid;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_bytes <= CAPACITY_RESET;
			cfg_q.ns_per_token <= NS_PER_TOKEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BURST_BYTES:  cfg_q.burst_bytes <= cfg_data;
				REG_NS_PER_TOKEN: cfg_q.ns_per_token <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ptbp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.frame   (frame),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	ptbp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.result    (result),
		.res_pop   (pop)
	);

	assign empty = !res_valid;
endmodule

/* sv/ptbp_checker.sv */
// Port-level checks of the policer, bound to the top level.
`include "per_destination_token_bucket_policer_macros.svh"

module ptbp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input ptbp_pkg::out_item_t result,
	input logic                cfg_ready
);
	import ptbp_pkg::*;

	// Configuration is always taken
	`PTBP_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)
	// A dropped frame never created its bucket
	`PTBP_ASSERT_NOW(a_drop_not_new, !empty && result.verdict, !result.new_flow)
	// The front queue fills only by a push
	`PTBP_ASSERT_NEXT(a_full_needs_push, !full && !push, !full)
	// A waiting result holds until taken
	`PTBP_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))
endmodule

bind per_destination_token_bucket_policer ptbp_checker u_ptbp_checker (.*);

/* test/tb_per_destination_token_bucket_policer.sv */
// Testbench for the per-destination token bucket policer: random and directed frames checked
// against a cycle-free model of the bucket table.
`timescale 1ns / 1ps

module tb_per_destination_token_bucket_policer;
	import ptbp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t frame = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	per_destination_token_bucket_policer u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .frame(frame),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Bucket table copy and configuration
	logic [31:0] capacity_m;
	logic [31:0] ns_per_token_m;
	logic        slot_valid [TABLE_ENTRIES];
	logic [31:0] slot_key [TABLE_ENTRIES];
	logic [31:0] slot_tokens [TABLE_ENTRIES];
	logic [63:0] slot_time [TABLE_ENTRIES];
	int unsigned slot_rank [TABLE_ENTRIES];
	logic [63:0] drops_m;

	in_item_t  frames_pending [$];
	out_item_t verdicts_due [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	int push_gap = 0;
	int pop_wait = 0;
	logic [63:0] clock_ns = '0;
	logic [31:0] dest_pool [80];

	// Move slot s to the front of the recency order
	function automatic void touch_slot(int s, int unsigned lim);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (i != s && slot_valid[i] && slot_rank[i] < lim)
				slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic out_item_t police_frame(in_item_t f);
		out_item_t r;
		int hit;
		int free_s;
		int victim;
		int unsigned oldest;
		logic [63:0] earned;
		logic [63:0] tok;
		r = '0;
		hit = -1;
		free_s = -1;
		victim = -1;
		oldest = 0;
		if (f.captured_len >= MIN_HEADER_BYTES && f.ethertype == ETHERTYPE_IPV4) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (slot_valid[i]) begin
					if (slot_key[i] == f.dest_address && hit < 0)
						hit = i;
					if (victim < 0 || slot_rank[i] >= oldest) begin
						victim = i;
						oldest = slot_rank[i];
					end
				end else if (free_s < 0) begin
					free_s = i;
				end
			end
			if (hit < 0) begin
				if (free_s >= 0) begin
					slot_valid[free_s] = 1'b1;
					touch_slot(free_s, 32'hFFFF_FFFF);
					victim = free_s;
				end else begin
					touch_slot(victim, oldest);
				end
				slot_key[victim] = f.dest_address;
				slot_tokens[victim] = capacity_m;
				slot_time[victim] = f.timestamp_ns;
				r.new_flow = 1'b1;
			end else begin
				earned = (ns_per_token_m == 0) ? '1 :
					(f.timestamp_ns - slot_time[hit]) / {32'd0, ns_per_token_m};
				if (earned > {30'd0, EARNED_MAX})
					earned = {30'd0, EARNED_MAX};
				tok = {32'd0, slot_tokens[hit]} + earned;
				if (tok > {32'd0, capacity_m})
					tok = {32'd0, capacity_m};
				slot_time[hit] = f.timestamp_ns;
				touch_slot(hit, slot_rank[hit]);
				if (tok >= {48'd0, f.frame_len}) begin
					tok -= {48'd0, f.frame_len};
				end else begin
					r.verdict = 1'b1;
					drops_m++;
				end
				slot_tokens[hit] = tok[31:0];
			end
		end
		r.drop_total = drops_m;
		return r;
	endfunction

	// Frame driver: predict on each transfer, then wait out a drawn gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				verdicts_due.push_back(police_frame(frame));
			if (!push || !full) begin
				if (push_gap > 0) begin
					push_gap--;
					push <= 1'b0;
				end else if (frames_pending.size() > 0) begin
					frame <= frames_pending.pop_front();
					push <= 1'b1;
					push_gap = no_gaps ? 0 : $urandom_range(0, 14);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", result);
				end else begin
					want = verdicts_due.pop_front();
					if (result.verdict !== want.verdict || result.new_flow !== want.new_flow
							|| result.drop_total !== want.drop_total) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected v=%0b n=%0b d=%0d, got v=%0b n=%0b d=%0d",
								want.verdict, want.new_flow, want.drop_total,
								result.verdict, result.new_flow, result.drop_total);
					end
				end
				pop_wait = no_gaps ? 0 : $urandom_range(0, 14);
			end
			if (pop_wait > 0) begin
				pop_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Register writes: update the model and drop valid on transfer
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BURST_BYTES)
				capacity_m = cfg_data;
			else if (cfg_index == REG_NS_PER_TOKEN)
				ns_per_token_m = cfg_data;
			cfg_valid <= 1'b0;
		end
	end

	// Watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 5000) begin
			$display("tb_per_destination_token_bucket_policer NOT OK");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		wait (!cfg_valid);
	endtask

	task automatic drain();
		wait (frames_pending.size() == 0 && !push && verdicts_due.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic in_item_t ipv4_frame(logic [31:0] dst, logic [15:0] len, logic [63:0] ts);
		in_item_t f;
		f.captured_len = MIN_HEADER_BYTES + 16'($urandom_range(0, 1500));
		f.ethertype = ETHERTYPE_IPV4;
		f.dest_address = dst;
		f.frame_len = len;
		f.timestamp_ns = ts;
		return f;
	endfunction

	task automatic random_frames(int n);
		in_item_t f;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: clock_ns += 64'($urandom_range(0, 1000));
				1: clock_ns += {32'd0, $urandom};
				2: clock_ns += {$urandom, $urandom};
				3: clock_ns += {$urandom_range(0, 3), $urandom};
				default: clock_ns += 64'($urandom_range(0, 100000));
			endcase
			if ($urandom_range(0, 9) == 0) begin
				// noise: random header fields, mostly failing the parse checks
				f = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
				if ($urandom_range(0, 1))
					f.captured_len = 16'($urandom_range(0, 33));
			end else begin
				f = ipv4_frame(dest_pool[$urandom_range(0, 79)],
					$urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1600)),
					clock_ns);
				if ($urandom_range(0, 7) == 0)
					f.captured_len = 16'($urandom_range(34, 65535));
			end
			frames_pending.push_back(f);
		end
	endtask

	initial begin
		in_item_t f;
		capacity_m = CAPACITY_RESET;
		ns_per_token_m = NS_PER_TOKEN_RESET;
		drops_m = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_rank[i] = 0;
			slot_key[i] = '0;
			slot_tokens[i] = '0;
			slot_time[i] = '0;
		end
		foreach (dest_pool[i])
			dest_pool[i] = $urandom;
		dest_pool[0] = '0;
		dest_pool[1] = '1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: parse checks, new flow, charge, drop, zero length, wrap
		f = ipv4_frame(32'hC0A8_0001, 16'd100, 64'd1000);
		f.captured_len = 16'd33;
		frames_pending.push_back(f);
		f.captured_len = 16'hFFFF;
		f.ethertype = 16'h86DD;
		frames_pending.push_back(f);
		f = ipv4_frame(32'hC0A8_0001, 16'd100, 64'd1000);
		f.captured_len = MIN_HEADER_BYTES;
		frames_pending.push_back(f);
		frames_pending.push_back(ipv4_frame(32'hC0A8_0001, 16'hFFFF, 64'd2000));
		frames_pending.push_back(ipv4_frame(32'hC0A8_0001, 16'hFFFF, 64'd3000));
		frames_pending.push_back(ipv4_frame(32'hC0A8_0001, 16'd0, 64'd3000));
		frames_pending.push_back(ipv4_frame(32'hFFFF_FFFF, 16'd0, 64'hFFFF_FFFF_FFFF_FF00));
		frames_pending.push_back(ipv4_frame(32'hFFFF_FFFF, 16'hFFFF, 64'd500));
		frames_pending.push_back(ipv4_frame(32'h0000_0000, 16'd1, '1));
		frames_pending.push_back(ipv4_frame(32'h0000_0000, 16'd1, '1));
		drain();

		// Tiny bucket, fastest refill
		write_reg(REG_BURST_BYTES, 32'd1);
		write_reg(REG_NS_PER_TOKEN, 32'd1);
		frames_pending.push_back(ipv4_frame(32'h0A00_0001, 16'd0, 64'd10));
		frames_pending.push_back(ipv4_frame(32'h0A00_0001, 16'd2, 64'd20));
		frames_pending.push_back(ipv4_frame(32'h0A00_0001, 16'd1, 64'd20));
		frames_pending.push_back(ipv4_frame(32'hC0A8_0001, 16'd1, 64'd4000));
		random_frames(60);
		drain();

		// Largest bucket, slowest refill
		no_gaps = 1'b1;
		write_reg(REG_BURST_BYTES, 32'hFFFF_FFFF);
		write_reg(REG_NS_PER_TOKEN, 32'hFFFF_FFFF);
		random_frames(70);
		drain();

		no_gaps = 1'b0;
		write_reg(REG_BURST_BYTES, 32'd1500);
		write_reg(REG_NS_PER_TOKEN, 32'd1);
		random_frames(90);
		drain();

		write_reg(REG_BURST_BYTES, 32'd40000);
		write_reg(REG_NS_PER_TOKEN, 32'd8);
		random_frames(90);
		drain();

		write_reg(REG_BURST_BYTES, $urandom_range(1, 100000));
		write_reg(REG_NS_PER_TOKEN, $urandom);
		random_frames(90);
		drain();
		repeat (200) @(posedge clk);

		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("tb_per_destination_token_bucket_policer OK");
		else
			$display("tb_per_destination_token_bucket_policer NOT OK");
		$finish;
	end
endmodule
